/* rtl/core/caf_pkg.sv */
// Shared types, constants and fixed-point helpers of the complementary attitude filter.
package caf_pkg;

  // Angles and estimates: LSB 2^-16 degree, held within +-180 degrees.
  localparam int unsigned ANGLE_W = 25;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  localparam logic signed [47:0] HALF_TURN_WIDE = 48'sd11796480;
  localparam angle_t             HALF_TURN      = 25'sd11796480;

  // CORDIC datapath: operands are the inputs scaled by 2^14.
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned CORDIC_Z_W   = 26;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned CNT_W        = $clog2(ATAN_ENTRIES);

  // Square root of a 32-bit radicand shifted up by 28 bits: 30 root bits.
  localparam int unsigned SQRT_STEPS  = 30;
  localparam int unsigned SQRT_CNT_W  = $clog2(SQRT_STEPS);

  // Shared multiplier operand widths.
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 29;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

  localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd64225;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd655;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQ_SUM,
    ST_ROOT,
    ST_PITCH,
    ST_RATE,
    ST_PRED,
    ST_MUL_A,
    ST_MUL_B,
    ST_MIX,
    ST_OUT
  } caf_state_e;

  // atan(2^-i) in degrees, LSB 2^-16.
  function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic [21:0] val;
    unique case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

  // Right shift rounding to nearest, halves away from zero; s is a constant at each use.
  function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
                                                 input int unsigned s);
    logic [47:0] mag;
    logic [47:0] res;
    mag = v[47] ? -v : v;
    res = (mag + (48'd1 << (s - 1))) >> s;
    return v[47] ? -$signed(res) : $signed(res);
  endfunction

  // Clamp to +-180 degrees.
  function automatic angle_t sat_half(input logic signed [47:0] v);
    angle_t res;
    if (v > HALF_TURN_WIDE) begin
      res = HALF_TURN;
    end else if (v < -HALF_TURN_WIDE) begin
      res = -HALF_TURN;
    end else begin
      res = v[ANGLE_W-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/caf_mul.sv */
// Shared signed multiplier with a registered product.
module caf_mul import caf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [MUL_A_W-1:0] a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [MUL_P_W-1:0] prod_o
);

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/caf_isqrt.sv */
// Bit-pair restoring integer square root of a radicand shifted up by 28 bits.
module caf_isqrt import caf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [31:0] rad_i,
  output logic        done_o,
  output logic [SQRT_STEPS-1:0] root_o
);

  logic                  busy_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic [59:0]           val_q;
  logic [30:0]           rem_q;
  logic [SQRT_STEPS-1:0] root_q;

  logic [32:0] rem_sh;
  logic [32:0] trial;
  logic        fits;

  always_comb begin
    rem_sh = {rem_q, val_q[59:58]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      val_q  <= {rad_i, 28'd0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[57:0], 2'b00};
      if (fits) begin
        rem_q  <= 31'(rem_sh - trial);
        root_q <= {root_q[SQRT_STEPS-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[30:0];
        root_q <= {root_q[SQRT_STEPS-2:0], 1'b0};
      end
    end
  end

  assign done_o = !busy_q;
  assign root_o = root_q;

  // After k steps the partial root has no more than k bits.
  a_root_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (root_q >> cnt_q) == '0)
    else $error("isqrt partial root wider than the steps taken");

endmodule

/* rtl/core/caf_cordic.sv */
// Vectoring CORDIC giving atan2(y, x) in degrees, one micro-rotation per cycle.
module caf_cordic import caf_pkg::*; #(
  parameter int unsigned STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic signed [CORDIC_W-1:0] x_i,
  input  logic signed [CORDIC_W-1:0] y_i,
  output logic                       done_o,
  output angle_t                     angle_o
);

  localparam logic signed [CORDIC_Z_W-1:0] HALF_Z = CORDIC_Z_W'(HALF_TURN);

  logic                         busy_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         zero_q;
  logic signed [CORDIC_W-1:0]   x_q;
  logic signed [CORDIC_W-1:0]   y_q;
  logic signed [CORDIC_Z_W-1:0] z_q;

  logic signed [CORDIC_W-1:0]   dx;
  logic signed [CORDIC_W-1:0]   dy;
  logic signed [CORDIC_Z_W-1:0] step_ang;

  always_comb begin
    dx       = y_q >>> cnt_q;
    dy       = x_q >>> cnt_q;
    step_ang = $signed({4'd0, atan_entry(cnt_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(STEPS - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      zero_q <= (x_i == '0) && (y_i == '0);
      // A vector in the left half-plane is turned by half a turn first.
      if (x_i[CORDIC_W-1]) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= y_i[CORDIC_W-1] ? -HALF_Z : HALF_Z;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + step_ang;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - step_ang;
      end
    end
  end

  assign done_o  = !busy_q;
  assign angle_o = zero_q ? '0 : sat_half({{(48 - CORDIC_Z_W){z_q[CORDIC_Z_W-1]}}, z_q});

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= CNT_W'(STEPS - 1))
    else $error("CORDIC step count past the last table entry in use");

endmodule

/* rtl/core/complementary_attitude_filter_unit.sv */
// Inputs: a word is taken only while idle; the input then stalls until the result has gone to
// the output register. The work per word is the 30-step square root with the roll pass of the
// shared CORDIC alongside it, then the pitch pass, then the multiply states for both axes.
// Reset clears the estimates to zero, loads the default blend weight and sample period,
// and leaves the block idle with no result pending.
module complementary_attitude_filter_unit import caf_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   accel_x_i,
  input  logic signed [15:0]   accel_y_i,
  input  logic signed [15:0]   accel_z_i,
  input  logic signed [15:0]   roll_rate_i,
  input  logic signed [15:0]   pitch_rate_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   roll_angle_o,
  output logic signed [15:0]   pitch_angle_o
);

  localparam int unsigned CORDIC_ITER =
      (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  caf_state_e state_q, state_d;

  logic [15:0] alpha_q;
  logic [15:0] dt_q;
  angle_t      est_roll_q;
  angle_t      est_pitch_q;
  logic        axis_q;
  logic        out_valid_q;

  logic signed [15:0] ax_q, ay_q, az_q, gr_q, gp_q;
  logic [30:0]              sq_q;
  angle_t                   acc_roll_q;
  logic signed [MUL_B_W-1:0] pred_q;
  logic signed [47:0]       mix_q;
  logic signed [15:0]       roll_out_q, pitch_out_q;

  logic                      in_accept;
  logic                      out_free;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic                      sq_load;
  logic                      sq_done;
  logic [31:0]               rad;
  logic [SQRT_STEPS-1:0]     root;
  logic                      cor_load;
  logic                      cor_done;
  logic signed [CORDIC_W-1:0] cor_x, cor_y;
  angle_t                    cor_angle;

  angle_t             est_cur;
  angle_t             acc_cur;
  logic signed [15:0] rate_cur;
  logic signed [47:0] prod_wide;
  logic signed [47:0] incr;
  logic signed [MUL_B_W-1:0] pred_d;
  logic signed [47:0] mix;
  angle_t             est_new;
  logic signed [47:0] roll_rnd, pitch_rnd;
  logic signed [CORDIC_W-1:0] ax_scaled;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  caf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  caf_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (sq_load),
    .rad_i  (rad),
    .done_o (sq_done),
    .root_o (root)
  );

  caf_cordic #(
    .STEPS (CORDIC_ITER)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cor_load),
    .x_i     (cor_x),
    .y_i     (cor_y),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  // Datapath values derived from the current axis and the multiplier output.
  always_comb begin
    est_cur   = axis_q ? est_pitch_q : est_roll_q;
    acc_cur   = axis_q ? cor_angle : acc_roll_q;
    rate_cur  = axis_q ? gp_q : gr_q;
    prod_wide = {prod[MUL_P_W-1], prod};
    incr      = rnd_shr(prod_wide, 4);
    pred_d    = {{(MUL_B_W - ANGLE_W){est_cur[ANGLE_W-1]}}, est_cur} + incr[MUL_B_W-1:0];
    mix       = mix_q + prod_wide;
    est_new   = sat_half(rnd_shr(mix, 16));
    roll_rnd  = rnd_shr({{(48 - ANGLE_W){est_roll_q[ANGLE_W-1]}}, est_roll_q}, 9);
    pitch_rnd = rnd_shr({{(48 - ANGLE_W){est_pitch_q[ANGLE_W-1]}}, est_pitch_q}, 9);
    rad       = {1'b0, sq_q} + {1'b0, prod[30:0]};
    ax_scaled = {{4{ax_q[15]}}, ax_q, 14'd0};
  end

  always_comb begin
    state_d  = state_q;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    sq_load  = 1'b0;
    cor_load = 1'b0;
    cor_x    = {{4{az_q[15]}}, az_q, 14'd0};
    cor_y    = {{4{ay_q[15]}}, ay_q, 14'd0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SQ_Y;
        end
      end
      ST_SQ_Y: begin
        mul_en  = 1'b1;
        mul_a   = {{2{ay_q[15]}}, ay_q};
        mul_b   = {{13{ay_q[15]}}, ay_q};
        state_d = ST_SQ_Z;
      end
      ST_SQ_Z: begin
        mul_en  = 1'b1;
        mul_a   = {{2{az_q[15]}}, az_q};
        mul_b   = {{13{az_q[15]}}, az_q};
        state_d = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        // The roll CORDIC runs alongside the square root.
        sq_load  = 1'b1;
        cor_load = 1'b1;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_done && cor_done) begin
          cor_load = 1'b1;
          cor_x    = {4'd0, root};
          cor_y    = -ax_scaled;
          state_d  = ST_PITCH;
        end
      end
      ST_PITCH: begin
        if (cor_done) begin
          state_d = ST_RATE;
        end
      end
      ST_RATE: begin
        mul_en  = 1'b1;
        mul_a   = {2'b00, dt_q};
        mul_b   = {{13{rate_cur[15]}}, rate_cur};
        state_d = ST_PRED;
      end
      ST_PRED: begin
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        mul_en  = 1'b1;
        mul_a   = {2'b00, alpha_q};
        mul_b   = pred_q;
        state_d = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_en  = 1'b1;
        mul_a   = {1'b0, 17'h10000 - {1'b0, alpha_q}};
        mul_b   = {{(MUL_B_W - ANGLE_W){acc_cur[ANGLE_W-1]}}, acc_cur};
        state_d = ST_MIX;
      end
      ST_MIX: begin
        state_d = axis_q ? ST_OUT : ST_RATE;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      alpha_q     <= BLEND_WEIGHT_RST;
      dt_q        <= SAMPLE_PERIOD_RST;
      est_roll_q  <= '0;
      est_pitch_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_BLEND_WEIGHT:  alpha_q <= cfg_data_i;
          REG_SAMPLE_PERIOD: dt_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_SQ_SUM) begin
        axis_q <= 1'b0;
      end else if (state_q == ST_MIX) begin
        axis_q <= 1'b1;
        if (axis_q) begin
          est_pitch_q <= est_new;
        end else begin
          est_roll_q <= est_new;
        end
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gr_q <= roll_rate_i;
      gp_q <= pitch_rate_i;
    end
    if (state_q == ST_SQ_Z) begin
      sq_q <= prod[30:0];
    end
    if (state_q == ST_ROOT && sq_done && cor_done) begin
      acc_roll_q <= cor_angle;
    end
    if (state_q == ST_PRED) begin
      pred_q <= pred_d;
    end
    if (state_q == ST_MUL_B) begin
      mix_q <= prod_wide;
    end
    if (state_q == ST_OUT && out_free) begin
      roll_out_q  <= roll_rnd[15:0];
      pitch_out_q <= pitch_rnd[15:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign roll_angle_o  = roll_out_q;
  assign pitch_angle_o = pitch_out_q;

  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (est_roll_q <= HALF_TURN) && (est_roll_q >= -HALF_TURN) &&
    (est_pitch_q <= HALF_TURN) && (est_pitch_q >= -HALF_TURN))
    else $error("attitude estimate outside +-180 degrees");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output state");

endmodule

/* sim/tb_complementary_attitude_filter_unit.sv */
// Self-checking testbench for the complementary attitude filter unit.
`timescale 1ns / 100ps

module tb_complementary_attitude_filter_unit import caf_pkg::*;;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned LATENCY      = CORDIC_STEPS + 46;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SEGMENT_LEN  = 130;
  localparam longint      ANGLE_LIMIT  = 64'sd11796480;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // atan(2^-i) in degrees, LSB 2^-16.
  localparam longint ARCTAN_Q16 [ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam logic [15:0] EDGE_VALUES [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
  } attitude_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [15:0]          cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic signed [15:0]   accel_x_i    = '0;
  logic signed [15:0]   accel_y_i    = '0;
  logic signed [15:0]   accel_z_i    = '0;
  logic signed [15:0]   roll_rate_i  = '0;
  logic signed [15:0]   pitch_rate_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic signed [15:0]   roll_angle_o;
  logic signed [15:0]   pitch_angle_o;

  // Predicted filter state and register copies.
  longint      roll_est;
  longint      pitch_est;
  int unsigned gyro_weight;
  int unsigned step_dt;

  attitude_t   pending_angles [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  complementary_attitude_filter_unit #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .roll_rate_i  (roll_rate_i),
    .pitch_rate_i (pitch_rate_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .roll_angle_o (roll_angle_o),
    .pitch_angle_o(pitch_angle_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint round_shr(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic longint clamp_angle(input longint v);
    if (v > ANGLE_LIMIT) return ANGLE_LIMIT;
    if (v < -ANGLE_LIMIT) return -ANGLE_LIMIT;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned place;
    root  = 0;
    place = 64'd1 << 62;
    while (place > v) place >>= 2;
    while (place != 0) begin
      if (v >= root + place) begin
        v    -= root + place;
        root  = (root >> 1) + place;
      end else begin
        root >>= 1;
      end
      place >>= 2;
    end
    return longint'(root);
  endfunction

  // Vectoring rotation: returns atan2(y, x) in degrees, LSB 2^-16.
  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     steps;
    x = x_in;
    y = y_in;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? ANGLE_LIMIT : -ANGLE_LIMIT;
      x = -x;
      y = -y;
    end
    steps = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q16[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q16[i];
      end
    end
    return clamp_angle(z);
  endfunction

  function automatic longint blend_axis(input longint est, input longint rate,
                                        input longint acc_angle);
    longint pred;
    longint mix;
    pred = est + round_shr(rate * longint'(step_dt), 4);
    mix  = longint'(gyro_weight) * pred + (64'sd65536 - longint'(gyro_weight)) * acc_angle;
    return clamp_angle(round_shr(mix, 16));
  endfunction

  function automatic attitude_t predict_attitude(input longint ax, input longint ay,
                                                 input longint az, input longint gr,
                                                 input longint gp);
    longint    mag;
    longint    acc_roll;
    longint    acc_pitch;
    longint    roll_out;
    longint    pitch_out;
    attitude_t res;
    mag       = int_sqrt((ay * ay + az * az) << 28);
    acc_roll  = vector_angle(ay * 16384, az * 16384);
    acc_pitch = vector_angle(-ax * 16384, mag);
    roll_est  = blend_axis(roll_est, gr, acc_roll);
    pitch_est = blend_axis(pitch_est, gp, acc_pitch);
    roll_out  = round_shr(roll_est, 9);
    pitch_out = round_shr(pitch_est, 9);
    res.roll  = roll_out[15:0];
    res.pitch = pitch_out[15:0];
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_BLEND_WEIGHT) begin
      gyro_weight = value;
    end else if (idx == REG_SAMPLE_PERIOD) begin
      step_dt = value;
    end
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input logic signed [15:0] gr,
                             input logic signed [15:0] gp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    accel_x_i    <= ax;
    accel_y_i    <= ay;
    accel_z_i    <= az;
    roll_rate_i  <= gr;
    pitch_rate_i <= gp;
    do @(posedge clk_i); while (in_stall_o);
    pending_angles.push_back(predict_attitude(ax, ay, az, gr, gp));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Level, zero vector, upside-down and full-scale samples at the reset settings.
  task automatic test_reset_defaults();
    send_sample(16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, -16'sd2511, 16'sd0, 16'sd0);
    send_sample(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767);
    send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_sample(16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
  endtask

  // Full gyro weight with the longest step drives both estimates into the clamp.
  task automatic test_gyro_saturation();
    wait_idle();
    write_reg(REG_BLEND_WEIGHT, 16'hFFFF);
    write_reg(REG_SAMPLE_PERIOD, 16'hFFFF);
    repeat (3) send_sample(16'sd0, 16'sd0, 16'sd2511, 16'sd32767, 16'sd32767);
    repeat (3) send_sample(16'sd0, 16'sd0, 16'sd2511, -16'sd32768, -16'sd32768);
  endtask

  // With a zero step the rates have no effect and each sample moves the estimates halfway to the accelerometer.
  task automatic test_zero_period();
    wait_idle();
    write_reg(REG_BLEND_WEIGHT, 16'd32768);
    write_reg(REG_SAMPLE_PERIOD, 16'd0);
    send_sample(16'sd1500, -16'sd1800, 16'sd900, 16'sd32767, -16'sd32768);
    send_sample(16'sd1500, -16'sd1800, 16'sd900, -16'sd32768, 16'sd32767);
    send_sample(-16'sd700, 16'sd0, -16'sd2000, 16'sd1000, 16'sd1000);
  endtask

  // Writes to the spare indexes must leave both registers untouched.
  task automatic test_spare_indexes();
    wait_idle();
    write_reg(REG_BLEND_WEIGHT, 16'd0);
    write_reg(REG_SAMPLE_PERIOD, 16'd1);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h5555);
    send_sample(16'sd2000, 16'sd1200, -16'sd300, 16'sd500, -16'sd500);
    send_sample(-16'sd2000, -16'sd1200, 16'sd300, -16'sd500, 16'sd500);
    send_sample(16'sd0, 16'sd2511, 16'sd0, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_traffic();
    logic [15:0] weight;
    logic [15:0] period;
    logic [15:0] word_val [5];
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 9 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        case ($urandom_range(3))
          0:       weight = 16'd0;
          1:       weight = 16'hFFFF;
          2:       weight = BLEND_WEIGHT_RST;
          default: weight = 16'($urandom);
        endcase
        case ($urandom_range(4))
          0:       period = 16'd0;
          1:       period = 16'd1;
          2:       period = 16'hFFFF;
          3:       period = SAMPLE_PERIOD_RST;
          default: period = 16'($urandom);
        endcase
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, weight);
        write_reg(REG_SAMPLE_PERIOD, period);
        repeat (SEGMENT_LEN) begin
          // Plausible motion as the most common case, with full-range, tiny and edge words mixed in.
          case ($urandom_range(9))
            0, 1, 2: begin
              for (int k = 0; k < 5; k++) word_val[k] = 16'($urandom);
            end
            3, 4, 5, 6: begin
              for (int k = 0; k < 3; k++) word_val[k] = 16'($urandom_range(8191)) - 16'd4096;
              for (int k = 3; k < 5; k++) word_val[k] = 16'($urandom_range(4095)) - 16'd2048;
            end
            7, 8: begin
              for (int k = 0; k < 5; k++) word_val[k] = 16'($urandom_range(8)) - 16'd4;
            end
            default: begin
              for (int k = 0; k < 5; k++) word_val[k] = EDGE_VALUES[$urandom_range(4)];
            end
          endcase
          send_sample(word_val[0], word_val[1], word_val[2], word_val[3], word_val[4]);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    attitude_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result word: roll %0d pitch %0d", roll_angle_o, pitch_angle_o);
        mismatch_count++;
      end else begin
        want = pending_angles.pop_front();
        if (roll_angle_o !== want.roll) begin
          $error("roll_angle: expected %0d, got %0d", want.roll, roll_angle_o);
          mismatch_count++;
        end
        if (pitch_angle_o !== want.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", want.pitch, pitch_angle_o);
          mismatch_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_complementary_attitude_filter_unit NOT OK");
      $finish;
    end
  end

  initial begin
    roll_est    = 0;
    pitch_est   = 0;
    gyro_weight = BLEND_WEIGHT_RST;
    step_dt     = SAMPLE_PERIOD_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_gyro_saturation();
    test_zero_period();
    test_spare_indexes();
    test_random_traffic();

    wait_idle();
    repeat (LATENCY + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_complementary_attitude_filter_unit OK");
    end else begin
      $display("tb_complementary_attitude_filter_unit NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/caf_pkg.sv
rtl/core/caf_mul.sv
rtl/core/caf_isqrt.sv
rtl/core/caf_cordic.sv
rtl/core/complementary_attitude_filter_unit.sv
sim/tb_complementary_attitude_filter_unit.sv
